/* design/cfbd_pkg.sv */
// Package for the capture frequency band detector.
// Holds register indexes, reset values and the shared struct types.
// No dependencies.
`default_nettype none

package cfbd_pkg;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [2:0] REG_TICK_RATE  = 3'd0;
    localparam logic [2:0] REG_GREEN_LOW  = 3'd1;
    localparam logic [2:0] REG_GREEN_HIGH = 3'd2;
    localparam logic [2:0] REG_RED_LOW    = 3'd3;
    localparam logic [2:0] REG_RED_HIGH   = 3'd4;
    localparam logic [2:0] REG_BLUE_LOW   = 3'd5;
    localparam logic [2:0] REG_BLUE_HIGH  = 3'd6;

    // Register values after reset.
    localparam logic [23:0] RST_TICK_RATE  = 24'd250000;
    localparam logic [15:0] RST_GREEN_LOW  = 16'd23;
    localparam logic [15:0] RST_GREEN_HIGH = 16'd27;
    localparam logic [15:0] RST_RED_LOW    = 16'd660;
    localparam logic [15:0] RST_RED_HIGH   = 16'd663;
    localparam logic [15:0] RST_BLUE_LOW   = 16'd195;
    localparam logic [15:0] RST_BLUE_HIGH  = 16'd205;

    // Width of the clamped period used by the band multipliers. Any period at
    // or above 2^24 is larger than every tick rate, so clamping it there keeps
    // the comparisons exact.
    localparam int SAT_W = 25;

    // Event codes of the op field.
    localparam logic OP_OVERFLOW = 1'b0;
    localparam logic OP_CAPTURE  = 1'b1;

    // Configuration register set.
    typedef struct packed {
        logic [23:0] tick_rate;
        logic [15:0] green_low;
        logic [15:0] green_high;
        logic [15:0] red_low;
        logic [15:0] red_high;
        logic [15:0] blue_low;
        logic [15:0] blue_high;
    } t_cfg;

    // Band test results for one period.
    typedef struct packed {
        logic green;
        logic red;
        logic blue;
    } t_band_hits;

endpackage

`default_nettype wire

/* design/cfbd_in_if.sv */
// Input channel of the band detector: timer events.
// Carries valid, ready and the event payload. No dependencies.
`default_nettype none

interface cfbd_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] capture_value;

    modport source (output valid, output op, output capture_value, input ready);
    modport sink   (input valid, input op, input capture_value, output ready);
endinterface

`default_nettype wire

/* design/cfbd_out_if.sv */
// Output channel of the band detector: one item per capture edge.
// Carries valid, ready and the LED and period payload. No dependencies.
`default_nettype none

interface cfbd_out_if;
    logic               valid;
    logic               ready;
    logic               green_led;
    logic               red_led;
    logic               blue_led;
    logic signed [32:0] period_ticks;
    logic               period_valid;

    modport source (output valid, output green_led, output red_led, output blue_led,
                    output period_ticks, output period_valid, input ready);
    modport sink   (input valid, input green_led, input red_led, input blue_led,
                    input period_ticks, input period_valid, output ready);
endinterface

`default_nettype wire

/* design/cfbd_regs.sv */
// Configuration register file with an APB-style write and read port.
// Depends on cfbd_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module cfbd_regs
    import cfbd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_rate  <= RST_TICK_RATE;
            r_cfg.green_low  <= RST_GREEN_LOW;
            r_cfg.green_high <= RST_GREEN_HIGH;
            r_cfg.red_low    <= RST_RED_LOW;
            r_cfg.red_high   <= RST_RED_HIGH;
            r_cfg.blue_low   <= RST_BLUE_LOW;
            r_cfg.blue_high  <= RST_BLUE_HIGH;
        end else if (wr_en) begin
            case (idx)
                REG_TICK_RATE:  r_cfg.tick_rate  <= pwdata[23:0];
                REG_GREEN_LOW:  r_cfg.green_low  <= pwdata[15:0];
                REG_GREEN_HIGH: r_cfg.green_high <= pwdata[15:0];
                REG_RED_LOW:    r_cfg.red_low    <= pwdata[15:0];
                REG_RED_HIGH:   r_cfg.red_high   <= pwdata[15:0];
                REG_BLUE_LOW:   r_cfg.blue_low   <= pwdata[15:0];
                REG_BLUE_HIGH:  r_cfg.blue_high  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (idx)
            REG_TICK_RATE:  prdata = {8'd0, r_cfg.tick_rate};
            REG_GREEN_LOW:  prdata = {16'd0, r_cfg.green_low};
            REG_GREEN_HIGH: prdata = {16'd0, r_cfg.green_high};
            REG_RED_LOW:    prdata = {16'd0, r_cfg.red_low};
            REG_RED_HIGH:   prdata = {16'd0, r_cfg.red_high};
            REG_BLUE_LOW:   prdata = {16'd0, r_cfg.blue_low};
            REG_BLUE_HIGH:  prdata = {16'd0, r_cfg.blue_high};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* design/cfbd_period.sv */
// Period measurement: previous capture, saturating overflow tally and the
// period subtraction. Depends on cfbd_pkg for SAT_W.
`default_nettype none

module cfbd_period
    import cfbd_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_ovf_take,
    input  wire logic             i_cap_take,
    input  wire logic [15:0]      i_cap_value,
    output logic      [32:0]      o_period,
    output logic                  o_positive,
    output logic      [SAT_W-1:0] o_period_sat
);

    localparam int BW = TIMER_BITS + 16;
    localparam int DW = (BW + 1 > 33) ? BW + 1 : 33;

    logic [15:0]            r_prev;
    logic [15:0]            r_tally;
    logic [TIMER_BITS+15:0] cap_wide;
    logic [TIMER_BITS-1:0]  cap_tb;
    logic [TIMER_BITS+15:0] cap_back;
    logic [BW-1:0]          base;
    logic [DW-1:0]          diff;

    // Capture masked to the timer width, then back to the stored 16 bits.
    assign cap_wide = {{TIMER_BITS{1'b0}}, i_cap_value};
    assign cap_tb   = cap_wide[TIMER_BITS-1:0];
    assign cap_back = {16'd0, cap_tb};

    // The capture never exceeds the timer range, so the add is a concatenation.
    assign base = {r_tally, cap_tb};
    assign diff = DW'(base) - DW'(r_prev);

    assign o_period   = diff[32:0];
    assign o_positive = base > BW'(r_prev);

    // Clamp large periods to 2^24 for the band multipliers.
    always_comb begin
        if (diff[DW-1:SAT_W-1] != '0) begin
            o_period_sat = {1'b1, {(SAT_W-1){1'b0}}};
        end else begin
            o_period_sat = diff[SAT_W-1:0];
        end
    end

    // State update on each accepted event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 16'd0;
            r_tally <= 16'd0;
        end else if (i_cap_take) begin
            r_prev  <= cap_back[15:0];
            r_tally <= 16'd0;
        end else if (i_ovf_take && (r_tally != 16'hFFFF)) begin
            r_tally <= r_tally + 16'd1;
        end
    end

endmodule

`default_nettype wire

/* design/cfbd_band.sv */
// Band tests: six cross-multiplied exclusive frequency comparisons.
// Depends on cfbd_pkg for t_cfg, t_band_hits and SAT_W.
`default_nettype none

module cfbd_band
    import cfbd_pkg::*;
(
    input  wire t_cfg              i_cfg,
    input  wire logic [SAT_W-1:0]  i_period_sat,
    output t_band_hits             o_hits
);

    localparam int PW = SAT_W + 16;

    logic [PW-1:0] rate;
    logic [PW-1:0] p_gl, p_gh, p_rl, p_rh, p_bl, p_bh;

    assign rate = PW'(i_cfg.tick_rate);

    // freq > low is rate > low * period; freq < high is rate < high * period.
    assign p_gl = PW'(i_cfg.green_low)  * PW'(i_period_sat);
    assign p_gh = PW'(i_cfg.green_high) * PW'(i_period_sat);
    assign p_rl = PW'(i_cfg.red_low)    * PW'(i_period_sat);
    assign p_rh = PW'(i_cfg.red_high)   * PW'(i_period_sat);
    assign p_bl = PW'(i_cfg.blue_low)   * PW'(i_period_sat);
    assign p_bh = PW'(i_cfg.blue_high)  * PW'(i_period_sat);

    assign o_hits.green = (rate > p_gl) && (rate < p_gh);
    assign o_hits.red   = (rate > p_rl) && (rate < p_rh);
    assign o_hits.blue  = (rate > p_bl) && (rate < p_bh);

endmodule

`default_nettype wire

/* design/capture_frequency_band_detector_core.sv */
// Top level of the capture frequency band detector.
// Depends on cfbd_pkg, cfbd_in_if, cfbd_out_if, cfbd_regs, cfbd_period, cfbd_band.
//
//  Channel   Direction  Handshake            Payload
//  i_item    in         valid/ready          op, capture_value
//  o_result  out        valid/ready          green_led, red_led, blue_led,
//                                            period_ticks, period_valid
//  APB       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One event is accepted per cycle while the input register is free or moving.
// A capture's period is taken into the input register at the edge that accepts
// it; the band multipliers and the LED update fill the result register once it
// is free or moving. Overflow ticks produce no result.
// Reset is synchronous and active low and restores the register defaults.
// A stalled output holds its item; one more capture waits in the input register.
`default_nettype none

module capture_frequency_band_detector_core
    import cfbd_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cfbd_in_if.sink          i_item,
    cfbd_out_if.source       o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg             cfg;
    t_band_hits       hits;
    logic             in_take;
    logic             cap_take;
    logic             ovf_take;
    logic [32:0]      period;
    logic             positive;
    logic [SAT_W-1:0] period_sat;
    logic             ld2;
    logic [2:0]       n_led;

    // Input and result registers.
    logic             r_v1;
    logic [32:0]      r_s1_period;
    logic             r_s1_pos;
    logic [SAT_W-1:0] r_s1_sat;
    logic             r_v2;
    logic [32:0]      r_s2_period;
    logic             r_s2_pos;
    logic [2:0]       r_s2_led;
    logic [2:0]       r_led;

    cfbd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: the input register moves when the result register is free or moving.
    assign ld2          = r_v1 && (!r_v2 || o_result.ready);
    assign i_item.ready = !r_v1 || ld2;
    assign in_take      = i_item.valid && i_item.ready;
    assign cap_take     = in_take && (i_item.op == OP_CAPTURE);
    assign ovf_take     = in_take && (i_item.op == OP_OVERFLOW);

    cfbd_period #(
        .TIMER_BITS (TIMER_BITS)
    ) u_period (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ovf_take   (ovf_take),
        .i_cap_take   (cap_take),
        .i_cap_value  (i_item.capture_value),
        .o_period     (period),
        .o_positive   (positive),
        .o_period_sat (period_sat)
    );

    cfbd_band u_band (
        .i_cfg        (cfg),
        .i_period_sat (r_s1_sat),
        .o_hits       (hits)
    );

    // Valid bits of the input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (cap_take) begin
                r_v1 <= 1'b1;
            end else if (ld2) begin
                r_v1 <= 1'b0;
            end
            if (ld2) begin
                r_v2 <= 1'b1;
            end else if (o_result.ready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    // Register payloads.
    always_ff @(posedge i_clk) begin
        if (cap_take) begin
            r_s1_period <= period;
            r_s1_pos    <= positive;
            r_s1_sat    <= period_sat;
        end
        if (ld2) begin
            r_s2_period <= r_s1_period;
            r_s2_pos    <= r_s1_pos;
            r_s2_led    <= n_led;
        end
    end

    // LED update: bit 0 green, bit 1 red, bit 2 blue; bands tried in order.
    always_comb begin
        n_led = r_led;
        if (r_s1_pos) begin
            if (hits.green) begin
                n_led = {r_led[2], 2'b01};
            end else if (hits.red) begin
                n_led = {r_led[2], 2'b10};
            end else if (hits.blue) begin
                n_led = 3'b100;
            end else begin
                n_led = 3'b000;
            end
        end
    end

    // LED state advances with each capture entering the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led <= 3'b000;
        end else if (ld2) begin
            r_led <= n_led;
        end
    end

    assign o_result.valid        = r_v2;
    assign o_result.green_led    = r_s2_led[0];
    assign o_result.red_led      = r_s2_led[1];
    assign o_result.blue_led     = r_s2_led[2];
    assign o_result.period_ticks = r_s2_period;
    assign o_result.period_valid = r_s2_pos;

    // An accepted capture always occupies the input register next cycle.
    a_cap_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cap_take |=> r_v1)
        else $error("accepted capture did not enter the input register");

    // The offered result carries the current LED state.
    a_led_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2_led == r_led))
        else $error("output LEDs differ from the LED state");

    // Green and red are never on together.
    a_led_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_led[0] && r_led[1]))
        else $error("green and red LEDs both on");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Testbench for capture_frequency_band_detector_core: timer events in, LED and period items out.
// Checks every result item against a local predictor and drives registers through APB.
// Depends on cfbd_pkg, cfbd_in_if, cfbd_out_if and the core itself.

module testbench;
    import cfbd_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int LONG_STALL = 120;
    localparam int LONG_STALL_AFTER = 40;

    // One result item as the core reports it.
    typedef struct packed {
        logic               green;
        logic               red;
        logic               blue;
        logic signed [32:0] period;
        logic               pvalid;
    } t_led_reading;

    // One directed row: overflow ticks, then one capture.
    typedef struct {
        int unsigned  wraps;
        logic [15:0]  cap;
        bit           typed;
        t_led_reading want;
    } t_capture_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cfbd_in_if  item_if ();
    cfbd_out_if result_if ();

    capture_frequency_band_detector_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state and configuration copy.
    t_cfg         band_cfg;
    logic [15:0]  last_capture;
    logic [15:0]  wrap_count;
    logic [2:0]   led_bits;
    t_led_reading pending_readings[$];
    t_led_reading oldest;

    int n_errors = 0;
    int n_results = 0;
    int rx_stall = 0;
    bit long_stall_done = 1'b0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    // Directed rows under the reset configuration (250000 ticks/s, bands 23-27,
    // 660-663 and 195-205 Hz). Rows with a typed result are trivially readable.
    t_capture_row dir_rows [17] = '{
        '{0,     16'd0,     1'b1, {3'b000, 33'sd0, 1'b0}},            // zero period
        '{0,     16'd65535, 1'b1, {3'b000, 33'sd65535, 1'b1}},        // slow, no band
        '{0,     16'd0,     1'b1, {3'b000, -33'sd65535, 1'b0}},       // most negative
        '{260,   16'd65535, 1'b1, {3'b000, 33'sd17104895, 1'b1}},     // period past 2^24
        '{1,     16'd377,   1'b0, '0},                                // red
        '{0,     16'd1627,  1'b0, '0},                                // blue
        '{0,     16'd11627, 1'b0, '0},                                // green, blue kept
        '{0,     16'd12005, 1'b0, '0},                                // red, blue kept
        '{0,     16'd12006, 1'b1, {3'b000, 33'sd1, 1'b1}},            // too fast, all off
        '{0,     16'd12006, 1'b1, {3'b000, 33'sd0, 1'b0}},            // zero, held
        '{0,     16'd13256, 1'b0, '0},                                // blue
        '{0,     16'd13000, 1'b0, '0},                                // negative, blue held
        '{0,     16'd13377, 1'b0, '0},                                // just above red
        '{0,     16'd13756, 1'b0, '0},                                // just below red
        '{2,     16'd0,     1'b0, '0},                                // across two wraps
        '{0,     16'd9260,  1'b0, '0},                                // green edge inside
        '{0,     16'd18519, 1'b0, '0}                                 // green edge outside
    };

    // Exclusive band test by cross-multiplication.
    function automatic bit in_band(input logic [63:0] span, input logic [15:0] lo,
                                   input logic [15:0] hi);
        logic [63:0] rate;
        rate = {40'd0, band_cfg.tick_rate};
        return (rate > {48'd0, lo} * span) && (rate < {48'd0, hi} * span);
    endfunction

    // Advances the predictor by one event; returns 1 when the event yields a result item.
    function automatic bit capture_step(input logic op, input logic [15:0] cap,
                                        output t_led_reading rd);
        logic [63:0] base;
        logic [63:0] span;
        bit          pos;
        rd = '0;
        if (op == OP_OVERFLOW) begin
            if (wrap_count != 16'hFFFF) begin
                wrap_count = wrap_count + 16'd1;
            end
            return 1'b0;
        end
        base = {32'd0, wrap_count, cap};
        span = base - {48'd0, last_capture};
        pos = base > {48'd0, last_capture};
        last_capture = cap;
        wrap_count = '0;
        if (pos) begin
            if (in_band(span, band_cfg.green_low, band_cfg.green_high)) begin
                led_bits = {led_bits[2], 2'b01};
            end else if (in_band(span, band_cfg.red_low, band_cfg.red_high)) begin
                led_bits = {led_bits[2], 2'b10};
            end else if (in_band(span, band_cfg.blue_low, band_cfg.blue_high)) begin
                led_bits = 3'b100;
            end else begin
                led_bits = 3'b000;
            end
        end
        rd.green = led_bits[0];
        rd.red = led_bits[1];
        rd.blue = led_bits[2];
        rd.period = span[32:0];
        rd.pvalid = pos;
        return 1'b1;
    endfunction

    // Register file copy; unknown indexes are ignored.
    function automatic void set_register(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_TICK_RATE:  band_cfg.tick_rate = data[23:0];
            REG_GREEN_LOW:  band_cfg.green_low = data[15:0];
            REG_GREEN_HIGH: band_cfg.green_high = data[15:0];
            REG_RED_LOW:    band_cfg.red_low = data[15:0];
            REG_RED_HIGH:   band_cfg.red_high = data[15:0];
            REG_BLUE_LOW:   band_cfg.blue_low = data[15:0];
            REG_BLUE_HIGH:  band_cfg.blue_high = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] register_value(input logic [2:0] idx);
        case (idx)
            REG_TICK_RATE:  return {8'd0, band_cfg.tick_rate};
            REG_GREEN_LOW:  return {16'd0, band_cfg.green_low};
            REG_GREEN_HIGH: return {16'd0, band_cfg.green_high};
            REG_RED_LOW:    return {16'd0, band_cfg.red_low};
            REG_RED_HIGH:   return {16'd0, band_cfg.red_high};
            REG_BLUE_LOW:   return {16'd0, band_cfg.blue_low};
            REG_BLUE_HIGH:  return {16'd0, band_cfg.blue_high};
            default:        return '0;
        endcase
    endfunction

    // Band bounds in the order green low, green high, red low, red high, blue low, blue high.
    function automatic logic [15:0] band_bound(input int sel);
        case (sel)
            0:       return band_cfg.green_low;
            1:       return band_cfg.green_high;
            2:       return band_cfg.red_low;
            3:       return band_cfg.red_high;
            4:       return band_cfg.blue_low;
            default: return band_cfg.blue_high;
        endcase
    endfunction

    // A narrow random band; now and then its bounds are swapped so it is empty.
    function automatic void pick_band(output logic [15:0] lo, output logic [15:0] hi);
        int unsigned f;
        int unsigned w;
        f = $urandom_range(50, 5000);
        w = $urandom_range(0, 40);
        lo = 16'(f - w);
        hi = 16'(f + w + 1);
        if ($urandom_range(0, 9) == 0) begin
            hi = lo;
            lo = 16'(f + w + 1);
        end
    endfunction

    // Offers one item, waits for acceptance and records what it should produce.
    task automatic send_event(input logic op, input logic [15:0] cap, input bit typed,
                              input t_led_reading want);
        t_led_reading rd;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.op <= op;
        item_if.capture_value <= cap;
        do @(posedge i_clk); while (!item_if.ready);
        if (capture_step(op, cap, rd)) begin
            pending_readings.push_back(typed ? want : rd);
        end
    endtask

    // Stops offering items and waits until every expected item has come out.
    task automatic drain_results();
        int guard;
        guard = 0;
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (pending_readings.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        set_register(idx, data);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic [2:0] idx);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== register_value(idx)) begin
            $error("register %0d: expected %0h, got %0h", idx, register_value(idx), prdata);
            n_errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes every register with junk in the unused upper bits, pokes the unused
    // index, then reads every register back.
    task automatic write_band_config(input logic [23:0] tick, input logic [15:0] gl,
                                     input logic [15:0] gh, input logic [15:0] rl,
                                     input logic [15:0] rh, input logic [15:0] bl,
                                     input logic [15:0] bh);
        write_register(REG_TICK_RATE, {8'($urandom), tick});
        write_register(REG_GREEN_LOW, {16'($urandom), gl});
        write_register(REG_GREEN_HIGH, {16'($urandom), gh});
        write_register(REG_RED_LOW, {16'($urandom), rl});
        write_register(REG_RED_HIGH, {16'($urandom), rh});
        write_register(REG_BLUE_LOW, {16'($urandom), bl});
        write_register(REG_BLUE_HIGH, {16'($urandom), bh});
        write_register(REG_UNUSED, $urandom);
        for (int i = 0; i < 7; i++) begin
            check_register(3'(i));
        end
    endtask

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_stall_done && n_results >= LONG_STALL_AFTER) begin
                long_stall_done = 1'b1;
                rx_stall = LONG_STALL;
            end
            if (rx_stall > 0) begin
                result_if.ready <= 1'b0;
                rx_stall--;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                result_if.ready <= 1'b0;
                rx_stall = $urandom_range(0, 16);
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            n_results++;
            if (pending_readings.size() == 0) begin
                $error("result item with nothing expected: period_ticks %0d",
                       $signed(result_if.period_ticks));
                n_errors++;
            end else begin
                oldest = pending_readings.pop_front();
                if (result_if.green_led !== oldest.green) begin
                    $error("green_led: expected %0b, got %0b", oldest.green,
                           result_if.green_led);
                    n_errors++;
                end
                if (result_if.red_led !== oldest.red) begin
                    $error("red_led: expected %0b, got %0b", oldest.red, result_if.red_led);
                    n_errors++;
                end
                if (result_if.blue_led !== oldest.blue) begin
                    $error("blue_led: expected %0b, got %0b", oldest.blue, result_if.blue_led);
                    n_errors++;
                end
                if (result_if.period_ticks !== oldest.period) begin
                    $error("period_ticks: expected %0d, got %0d", oldest.period,
                           $signed(result_if.period_ticks));
                    n_errors++;
                end
                if (result_if.period_valid !== oldest.pvalid) begin
                    $error("period_valid: expected %0b, got %0b", oldest.pvalid,
                           result_if.period_valid);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus: reset, directed rows, then random phases under several configurations.
    initial begin
        int           items;
        int           kind;
        int           sel;
        bit           aimed;
        longint       target;
        longint       span;
        longint       mid;
        int unsigned  wraps;
        logic [15:0]  cap;
        logic [23:0]  tick;
        logic [15:0]  gl, gh, rl, rh, bl, bh;
        t_led_reading none_rd;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_if.valid = 1'b0;
        item_if.op = OP_OVERFLOW;
        item_if.capture_value = '0;
        band_cfg = {RST_TICK_RATE, RST_GREEN_LOW, RST_GREEN_HIGH, RST_RED_LOW,
                    RST_RED_HIGH, RST_BLUE_LOW, RST_BLUE_HIGH};
        last_capture = '0;
        wrap_count = '0;
        led_bits = '0;
        none_rd = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers come out of reset with their defaults.
        for (int i = 0; i < 7; i++) begin
            check_register(3'(i));
        end

        // Directed rows; the long overflow run goes back to back.
        foreach (dir_rows[r]) begin
            tx_idle_on = dir_rows[r].wraps < 16;
            repeat (dir_rows[r].wraps) send_event(OP_OVERFLOW, 16'($urandom), 1'b0, none_rd);
            tx_idle_on = 1'b1;
            send_event(OP_CAPTURE, dir_rows[r].cap, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1: write_band_config(24'hFFFFFF, 16'h0000, 16'hFFFF, 16'hFFFF,
                                         16'hFFFF, 16'h0000, 16'hFFFF);
                    // Zero tick rate: no band can ever match.
                    2: write_band_config(24'h000000, 16'hFFFF, 16'h0000, 16'h0000,
                                         16'h0000, 16'hFFFF, 16'h0000);
                    default: begin
                        tick = (phase == 3) ? 24'd16000000 : 24'($urandom_range(1, 16000000));
                        pick_band(gl, gh);
                        pick_band(rl, rh);
                        pick_band(bl, bh);
                        // Red shadowed by green checks the band priority.
                        if (phase == 5) begin
                            rl = gl;
                            rh = gh;
                        end
                        write_band_config(tick, gl, gh, rl, rh, bl, bh);
                    end
                endcase
            end

            // The last phase runs with no idling on either side.
            tx_idle_on = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);

            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                kind = $urandom_range(0, 9);
                aimed = 1'b0;
                target = 0;
                wraps = 0;
                cap = 16'($urandom);
                case (kind)
                    0: wraps = $urandom_range(1, 3);
                    1: ;
                    2: cap = last_capture;
                    3: begin
                        aimed = 1'b1;
                        target = $urandom_range(1, 200000);
                    end
                    4, 5, 6: begin
                        // Aim near the middle of one band.
                        aimed = 1'b1;
                        sel = $urandom_range(0, 2);
                        mid = (longint'(band_bound(2 * sel)) + band_bound(2 * sel + 1)) / 2;
                        if (mid == 0 || band_cfg.tick_rate == 0) begin
                            target = $urandom_range(1, 1000);
                        end else begin
                            target = longint'(band_cfg.tick_rate) / mid
                                     + int'($urandom_range(0, 4)) - 2;
                        end
                    end
                    7, 8: begin
                        // Aim at a band edge, within one tick either side of it.
                        aimed = 1'b1;
                        mid = band_bound($urandom_range(0, 5));
                        target = (mid == 0) ? 1 : longint'(band_cfg.tick_rate) / mid
                                 + int'($urandom_range(0, 2)) - 1;
                    end
                    default: wraps = $urandom_range(1, 2);
                endcase
                if (aimed) begin
                    if (target < 1) begin
                        target = 1;
                    end
                    span = longint'(last_capture) + target;
                    wraps = ((span >> 16) > wrap_count) ? int'((span >> 16) - wrap_count) : 0;
                    cap = span[15:0];
                end
                repeat (wraps) send_event(OP_OVERFLOW, 16'($urandom), 1'b0, none_rd);
                items += wraps;
                if (kind != 0) begin
                    send_event(OP_CAPTURE, cap, 1'b0, none_rd);
                    items++;
                end
            end
        end

        drain_results();
        if (pending_readings.size() != 0) begin
            $error("%0d expected result items never arrived", pending_readings.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit, far beyond the slowest legal run.
    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/cfbd_pkg.sv
design/cfbd_in_if.sv
design/cfbd_out_if.sv
design/cfbd_regs.sv
design/cfbd_period.sv
design/cfbd_band.sv
design/capture_frequency_band_detector_core.sv
dv/testbench.sv
